>>> hw/rtl/gsa_pkg.sv
// Shared types, widths and codes of the generational slot allocator.
`default_nettype none
package gsa_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int KEY_W          = 16;
    localparam int TAG_W          = 16;
    localparam int HANDLE_W       = 64;
    localparam int PORT_IDX_W     = 10;
    localparam int PORT_CNT_W     = 11;

    typedef enum logic [2:0] {
        MODE_ALLOC        = 3'd0,
        MODE_FREE_HANDLE  = 3'd1,
        MODE_FREE_INDEX   = 3'd2,
        MODE_CHECK_HANDLE = 3'd3,
        MODE_CHECK_INDEX  = 3'd4,
        MODE_NEXT         = 3'd5,
        MODE_PREV         = 3'd6,
        MODE_CLEAR        = 3'd7
    } t_mode;

    typedef struct packed {
        logic [2:0]            mode;
        logic [HANDLE_W-1:0]   handle_in;
        logic [PORT_IDX_W-1:0] slot_index;
    } t_in_word;

    typedef struct packed {
        logic                  found;
        logic [HANDLE_W-1:0]   handle_out;
        logic [PORT_IDX_W-1:0] index_out;
        logic [PORT_CNT_W-1:0] used_count;
        logic [PORT_IDX_W-1:0] lowest_used;
        logic [PORT_IDX_W-1:0] highest_used;
    } t_out_word;

endpackage
`default_nettype wire

>>> hw/rtl/gsa_table.sv
// Slot table memory: one write port and one registered read port.
`default_nettype none
module gsa_table #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF,
    parameter int IDX_W      = $clog2(SLOT_COUNT),
    parameter int ROW_W      = gsa_pkg::KEY_W + IDX_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire logic [ROW_W-1:0] i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output logic      [ROW_W-1:0] o_rdata
);

    logic [ROW_W-1:0] r_mem [SLOT_COUNT];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> hw/rtl/generational_slot_allocator_top.sv
// Top level of the generational slot allocator: sequencer, registers and result word.
`default_nettype none
// The allocator keeps SLOT_COUNT slots in one single-port-read table, each
// holding a 16-bit generation key (zero while free) and a link that threads
// the free slots into a list. Every input word is handled on its own: it is
// taken when the sequencer is idle and the result register is empty or being
// emptied, and exactly one result word follows. For allocation, free and
// check operations the table is read at the edge that takes the word, and
// the result word is registered from the read data while the sequencer is
// still busy with the word. A free that removes the slot holding the lowest
// or highest used mark, and the next and previous searches, then walk the
// table slot by slot (address, then registered read data) before the result
// is shown. After reset, and for a clear word, the table is relinked by a
// clearing pass over all SLOT_COUNT slots during which no word is accepted;
// configuration writes of the bucket tag are taken at any time.
module generational_slot_allocator_top #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [gsa_pkg::TAG_W-1:0] i_cfg_wdata,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire gsa_pkg::t_in_word         i_in_word,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output gsa_pkg::t_out_word             o_out_word
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);
    localparam int KEY_W = gsa_pkg::KEY_W;
    localparam int ROW_W = KEY_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    typedef enum logic [4:0] {
        S_CLR  = 5'b00001,
        S_IDLE = 5'b00010,
        S_EXEC = 5'b00100,
        S_SRD  = 5'b01000,
        S_SCHK = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        SC_HIGH = 2'd0,
        SC_LOW  = 2'd1,
        SC_NEXT = 2'd2,
        SC_PREV = 2'd3
    } t_scan;

    t_state                     r_state, n_state;
    t_scan                      r_kind, n_kind;
    gsa_pkg::t_mode             r_mode, n_mode;
    logic [IDX_W-1:0]           r_ptr, n_ptr;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [gsa_pkg::HANDLE_W-1:0] r_hin, n_hin;
    logic [gsa_pkg::PORT_IDX_W-1:0] r_si, n_si;
    logic [KEY_W-1:0]           r_key, n_key;
    logic [IDX_W-1:0]           r_free_head, n_free_head;
    logic [KEY_W-1:0]           r_next_key, n_next_key;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [IDX_W-1:0]           r_low, n_low;
    logic [IDX_W-1:0]           r_high, n_high;
    logic [gsa_pkg::TAG_W-1:0]  r_tag;
    logic                       r_clr_reply, n_clr_reply;
    logic                       r_out_valid, n_out_valid;
    gsa_pkg::t_out_word         r_out, n_out;

    logic             tbl_we;
    logic [IDX_W-1:0] tbl_waddr;
    logic [ROW_W-1:0] tbl_wdata;
    logic [IDX_W-1:0] tbl_raddr;
    logic [ROW_W-1:0] tbl_rdata;
    logic [KEY_W-1:0] rd_key;
    logic [IDX_W-1:0] rd_link;

    logic             accept;
    logic             do_fin;
    logic             fin_found;
    logic [KEY_W-1:0] fin_key;
    logic [IDX_W-1:0] fin_idx;
    logic             ok;

    gsa_table #(
        .SLOT_COUNT (SLOT_COUNT),
        .IDX_W      (IDX_W),
        .ROW_W      (ROW_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    assign rd_key  = tbl_rdata[ROW_W-1:IDX_W];
    assign rd_link = tbl_rdata[IDX_W-1:0];

    // A word is taken only when the sequencer is idle and the result
    // register will be free at the same edge.
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        n_state     = r_state;
        n_kind      = r_kind;
        n_mode      = r_mode;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_hin       = r_hin;
        n_si        = r_si;
        n_key       = r_key;
        n_free_head = r_free_head;
        n_next_key  = r_next_key;
        n_count     = r_count;
        n_low       = r_low;
        n_high      = r_high;
        n_clr_reply = r_clr_reply;
        n_out_valid = r_out_valid && !i_out_ready;
        tbl_we      = 1'b0;
        tbl_waddr   = r_ptr;
        tbl_wdata   = '0;
        tbl_raddr   = r_ptr;
        do_fin      = 1'b0;
        fin_found   = 1'b0;
        fin_key     = r_key;
        fin_idx     = r_idx;
        ok          = 1'b0;

        case (r_state)
            S_CLR: begin
                // Relink one slot a cycle: free, pointing at its successor.
                tbl_we    = 1'b1;
                tbl_waddr = r_ptr;
                tbl_wdata = {KEY_W'(0), (r_ptr == LAST_IDX) ? IDX_W'(0) : r_ptr + IDX_W'(1)};
                n_ptr     = r_ptr + IDX_W'(1);
                if (r_ptr == LAST_IDX) begin
                    n_ptr       = '0;
                    n_state     = S_IDLE;
                    n_free_head = '0;
                    n_next_key  = KEY_W'(1);
                    n_count     = '0;
                    n_low       = '0;
                    n_high      = '0;
                    n_clr_reply = 1'b0;
                    if (r_clr_reply) begin
                        do_fin    = 1'b1;
                        fin_found = 1'b1;
                        fin_idx   = '0;
                    end
                end
            end

            S_IDLE: begin
                if (accept) begin
                    n_mode  = gsa_pkg::t_mode'(i_in_word.mode);
                    n_hin   = i_in_word.handle_in;
                    n_si    = i_in_word.slot_index;
                    n_state = S_EXEC;
                    case (gsa_pkg::t_mode'(i_in_word.mode))
                        gsa_pkg::MODE_ALLOC: begin
                            tbl_raddr = r_free_head;
                            n_idx     = r_free_head;
                        end
                        gsa_pkg::MODE_FREE_HANDLE, gsa_pkg::MODE_CHECK_HANDLE: begin
                            tbl_raddr = IDX_W'(i_in_word.handle_in[15:0]);
                            n_idx     = IDX_W'(i_in_word.handle_in[15:0]);
                        end
                        gsa_pkg::MODE_CLEAR: begin
                            n_state     = S_CLR;
                            n_ptr       = '0;
                            n_clr_reply = 1'b1;
                        end
                        default: begin
                            tbl_raddr = IDX_W'(i_in_word.slot_index);
                            n_idx     = IDX_W'(i_in_word.slot_index);
                        end
                    endcase
                end
            end

            S_EXEC: begin
                n_state = S_IDLE;
                case (r_mode)
                    gsa_pkg::MODE_ALLOC: begin
                        do_fin = 1'b1;
                        if (32'(r_count) < SLOT_COUNT) begin
                            tbl_we      = 1'b1;
                            tbl_waddr   = r_idx;
                            tbl_wdata   = {r_next_key, r_idx};
                            n_free_head = rd_link;
                            n_count     = r_count + CNT_W'(1);
                            n_next_key  = (r_next_key == '1) ? KEY_W'(1)
                                                             : r_next_key + KEY_W'(1);
                            if (r_high < r_idx) begin
                                n_high = r_idx;
                            end
                            if (r_low > r_idx) begin
                                n_low = r_idx;
                            end
                            fin_found = 1'b1;
                            fin_key   = r_next_key;
                        end
                    end

                    gsa_pkg::MODE_NEXT, gsa_pkg::MODE_PREV: begin
                        ok = (32'(r_si) < SLOT_COUNT) && (rd_key != '0)
                             && (32'(r_si) >= 32'(r_low))
                             && (32'(r_si) <= 32'(r_high) + 32'd1);
                        if (r_mode == gsa_pkg::MODE_NEXT) begin
                            if (ok && (32'(r_si) + 32'd1 <= 32'(r_high))) begin
                                n_kind  = SC_NEXT;
                                n_ptr   = IDX_W'(32'(r_si) + 32'd1);
                                n_state = S_SRD;
                            end else begin
                                do_fin = 1'b1;
                            end
                        end else begin
                            if (ok && (32'(r_si) > 32'(r_low))) begin
                                n_kind  = SC_PREV;
                                n_ptr   = r_idx - IDX_W'(1);
                                n_state = S_SRD;
                            end else begin
                                do_fin = 1'b1;
                            end
                        end
                    end

                    default: begin
                        if (r_mode == gsa_pkg::MODE_FREE_HANDLE
                                || r_mode == gsa_pkg::MODE_CHECK_HANDLE) begin
                            ok = (r_hin[63:48] == r_tag)
                                 && (32'(r_hin[15:0]) < SLOT_COUNT)
                                 && (rd_key != '0) && (rd_key == r_hin[31:16]);
                        end else begin
                            ok = (32'(r_si) < SLOT_COUNT) && (rd_key != '0);
                        end
                        fin_key = rd_key;
                        n_key   = rd_key;
                        if (ok && (r_mode == gsa_pkg::MODE_FREE_HANDLE
                                || r_mode == gsa_pkg::MODE_FREE_INDEX)) begin
                            // Push the slot onto the free list, then repair the
                            // marks if this slot held either of them.
                            tbl_we      = 1'b1;
                            tbl_waddr   = r_idx;
                            tbl_wdata   = {KEY_W'(0), r_free_head};
                            n_free_head = r_idx;
                            n_count     = r_count - CNT_W'(1);
                            if (r_high == r_idx && r_idx != '0) begin
                                n_kind  = SC_HIGH;
                                n_ptr   = r_idx - IDX_W'(1);
                                n_state = S_SRD;
                            end else if (r_low == r_idx && r_idx != LAST_IDX) begin
                                n_kind  = SC_LOW;
                                n_ptr   = r_idx + IDX_W'(1);
                                n_state = S_SRD;
                            end else begin
                                do_fin    = 1'b1;
                                fin_found = 1'b1;
                            end
                        end else begin
                            do_fin    = 1'b1;
                            fin_found = ok;
                        end
                    end
                endcase
            end

            S_SRD: begin
                tbl_raddr = r_ptr;
                n_state   = S_SCHK;
            end

            S_SCHK: begin
                n_state = S_SRD;
                case (r_kind)
                    SC_HIGH: begin
                        n_high = r_ptr;
                        if (rd_key != '0 || r_ptr == '0) begin
                            if (r_low == r_idx && r_idx != LAST_IDX) begin
                                n_kind = SC_LOW;
                                n_ptr  = r_idx + IDX_W'(1);
                            end else begin
                                n_state   = S_IDLE;
                                do_fin    = 1'b1;
                                fin_found = 1'b1;
                            end
                        end else begin
                            n_ptr = r_ptr - IDX_W'(1);
                        end
                    end
                    SC_LOW: begin
                        n_low = r_ptr;
                        if (rd_key != '0 || r_ptr == LAST_IDX) begin
                            n_state   = S_IDLE;
                            do_fin    = 1'b1;
                            fin_found = 1'b1;
                        end else begin
                            n_ptr = r_ptr + IDX_W'(1);
                        end
                    end
                    SC_NEXT: begin
                        if (rd_key != '0) begin
                            n_state   = S_IDLE;
                            do_fin    = 1'b1;
                            fin_found = 1'b1;
                            fin_key   = rd_key;
                            fin_idx   = r_ptr;
                        end else if (r_ptr >= r_high || r_ptr == LAST_IDX) begin
                            n_state = S_IDLE;
                            do_fin  = 1'b1;
                        end else begin
                            n_ptr = r_ptr + IDX_W'(1);
                        end
                    end
                    default: begin
                        if (rd_key != '0) begin
                            n_state   = S_IDLE;
                            do_fin    = 1'b1;
                            fin_found = 1'b1;
                            fin_key   = rd_key;
                            fin_idx   = r_ptr;
                        end else if (r_ptr <= r_low) begin
                            n_state = S_IDLE;
                            do_fin  = 1'b1;
                        end else begin
                            n_ptr = r_ptr - IDX_W'(1);
                        end
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // The result word reports the counters as they stand after the
        // operation; a miss or a clear carries a zero handle and index.
        // Handle bits 47..32 are always zero.
        n_out = r_out;
        if (do_fin) begin
            n_out_valid        = 1'b1;
            n_out.found        = fin_found;
            n_out.handle_out   = '0;
            n_out.index_out    = '0;
            if (fin_found && r_state != S_CLR) begin
                n_out.handle_out = {r_tag, 16'h0000, fin_key, 16'(fin_idx)};
                n_out.index_out  = gsa_pkg::PORT_IDX_W'(fin_idx);
            end
            n_out.used_count   = gsa_pkg::PORT_CNT_W'(n_count);
            n_out.lowest_used  = gsa_pkg::PORT_IDX_W'(n_low);
            n_out.highest_used = gsa_pkg::PORT_IDX_W'(n_high);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_kind      <= SC_HIGH;
            r_mode      <= gsa_pkg::MODE_ALLOC;
            r_ptr       <= '0;
            r_idx       <= '0;
            r_key       <= '0;
            r_free_head <= '0;
            r_next_key  <= KEY_W'(1);
            r_count     <= '0;
            r_low       <= '0;
            r_high      <= '0;
            r_tag       <= gsa_pkg::TAG_W'(1);
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind      <= n_kind;
            r_mode      <= n_mode;
            r_ptr       <= n_ptr;
            r_idx       <= n_idx;
            r_key       <= n_key;
            r_free_head <= n_free_head;
            r_next_key  <= n_next_key;
            r_count     <= n_count;
            r_low       <= n_low;
            r_high      <= n_high;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_tag <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hin <= n_hin;
        r_si  <= n_si;
        r_out <= n_out;
    end

endmodule
`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the generational slot allocator top level.
`timescale 1ns / 1ps
module testbench;

    localparam int NSLOT = 1024;

    // Clock, reset and the block's ports.
    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic [15:0] i_cfg_wdata = '0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    gsa_pkg::t_in_word  i_in_word = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    gsa_pkg::t_out_word o_out_word;

    always #2 i_clk = ~i_clk;

    generational_slot_allocator_top #(.SLOT_COUNT(NSLOT)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_word(o_out_word)
    );

    // Shadow copy of the allocator state, kept in step with every accepted word.
    logic [15:0] sh_key [NSLOT];
    logic [15:0] sh_link [NSLOT];
    int unsigned sh_head, sh_next_key, sh_used, sh_low, sh_high;
    logic [15:0] sh_tag;

    gsa_pkg::t_out_word pending_results[$];
    logic [63:0] live_handles[$];
    int          error_count = 0;
    int          result_count = 0;
    int          word_count = 0;
    int          burst_left = 0;
    int          stall_phase = 0;

    // Recovers the free list and the counters exactly as a clear or reset leaves them.
    function automatic void shadow_relink();
        for (int i = 0; i < NSLOT; i++) begin
            sh_key[i] = '0;
            sh_link[i] = (i + 1 < NSLOT) ? 16'(i + 1) : 16'd0;
        end
        sh_head = 0; sh_next_key = 1; sh_used = 0; sh_low = 0; sh_high = 0;
    endfunction

    function automatic logic [63:0] shadow_handle(int unsigned idx);
        return {sh_tag, 16'h0, sh_key[idx], 16'(idx)};
    endfunction

    // Frees one slot, pushes it on the list and rescans a mark that it held.
    function automatic void shadow_release(int unsigned idx);
        int unsigned i;
        sh_key[idx] = '0;
        sh_link[idx] = 16'(sh_head);
        sh_head = idx;
        sh_used--;
        if (sh_high == idx) begin
            i = idx;
            while (i > 0) begin
                i--;
                sh_high = i;
                if (sh_key[i] != 0) break;
            end
        end
        if (sh_low == idx) begin
            for (i = idx + 1; i < NSLOT; i++) begin
                sh_low = i;
                if (sh_key[i] != 0) break;
            end
        end
    endfunction

    function automatic gsa_pkg::t_out_word predict_result(gsa_pkg::t_in_word w);
        gsa_pkg::t_out_word r;
        logic        ok;
        int unsigned idx, si, hi, hk;
        logic [63:0] hout;
        ok = 1'b0; idx = 0; hout = '0;
        si = w.slot_index;
        case (gsa_pkg::t_mode'(w.mode))
            gsa_pkg::MODE_ALLOC: begin
                if (sh_used < NSLOT && sh_head < NSLOT) begin
                    idx = sh_head;
                    sh_head = sh_link[idx];
                    if (sh_head >= NSLOT) sh_head = 0;
                    sh_key[idx] = 16'(sh_next_key);
                    sh_link[idx] = 16'(idx);
                    hout = shadow_handle(idx);
                    sh_used++;
                    sh_next_key = (sh_next_key >= 16'hFFFF) ? 1 : sh_next_key + 1;
                    if (sh_high < idx) sh_high = idx;
                    if (sh_low > idx) sh_low = idx;
                    ok = 1'b1;
                end
            end
            gsa_pkg::MODE_FREE_HANDLE, gsa_pkg::MODE_CHECK_HANDLE: begin
                hi = w.handle_in[15:0];
                hk = w.handle_in[31:16];
                if (w.handle_in[63:48] == sh_tag && hi < NSLOT && sh_key[hi] != 0
                        && sh_key[hi] == hk) begin
                    idx = hi;
                    hout = shadow_handle(idx);
                    if (w.mode == gsa_pkg::MODE_FREE_HANDLE) shadow_release(idx);
                    ok = 1'b1;
                end
            end
            gsa_pkg::MODE_FREE_INDEX, gsa_pkg::MODE_CHECK_INDEX: begin
                if (sh_key[si] != 0) begin
                    idx = si;
                    hout = shadow_handle(idx);
                    if (w.mode == gsa_pkg::MODE_FREE_INDEX) shadow_release(idx);
                    ok = 1'b1;
                end
            end
            gsa_pkg::MODE_NEXT, gsa_pkg::MODE_PREV: begin
                if (sh_key[si] != 0 && si >= sh_low && si <= sh_high + 1) begin
                    if (w.mode == gsa_pkg::MODE_NEXT) begin
                        for (int unsigned i = si + 1; i <= sh_high && i < NSLOT; i++)
                            if (sh_key[i] != 0) begin
                                ok = 1'b1; idx = i; break;
                            end
                    end else begin
                        for (int unsigned i = si; i > sh_low; ) begin
                            i--;
                            if (sh_key[i] != 0) begin
                                ok = 1'b1; idx = i; break;
                            end
                        end
                    end
                    if (ok) hout = shadow_handle(idx);
                end
            end
            default: begin
                shadow_relink();
                ok = 1'b1;
            end
        endcase
        if (!ok || w.mode == gsa_pkg::MODE_CLEAR) begin
            hout = '0; idx = 0;
        end
        r.found = ok;
        r.handle_out = hout;
        r.index_out = 10'(idx);
        r.used_count = 11'(sh_used);
        r.lowest_used = 10'(sh_low);
        r.highest_used = 10'(sh_high);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Sends one word, holding valid until accepted; the sender may go quiet
    // between bursts of random length. Valid drops after each word, while the
    // block is busy with it anyway.
    task automatic send_word(gsa_pkg::t_mode m, logic [63:0] h, logic [9:0] si);
        gsa_pkg::t_in_word w;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        burst_left--;
        w.mode = m; w.handle_in = h; w.slot_index = si;
        i_in_word <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_result(w));
        if (m == gsa_pkg::MODE_ALLOC && pending_results[$].found)
            live_handles.push_back(pending_results[$].handle_out);
        if (m == gsa_pkg::MODE_CLEAR) live_handles.delete();
        word_count++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // The receiver stalls in patterns that change now and then (fixed repeating ones and a random one),
    // with long stretches of no stalls at all.
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        case ((stall_phase / 256) % 4)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= (stall_phase % 3) != 0;
            2: i_out_ready <= $urandom_range(0, 3) != 0;
            default: i_out_ready <= (stall_phase % 7) < 2;
        endcase
    end

    // Compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_out_word.handle_out, '0);
            end else begin
                gsa_pkg::t_out_word e;
                e = pending_results.pop_front();
                if (o_out_word.found !== e.found)
                    report_mismatch("found", o_out_word.found, e.found);
                if (o_out_word.handle_out !== e.handle_out)
                    report_mismatch("handle_out", o_out_word.handle_out, e.handle_out);
                if (o_out_word.index_out !== e.index_out)
                    report_mismatch("index_out", o_out_word.index_out, e.index_out);
                if (o_out_word.used_count !== e.used_count)
                    report_mismatch("used_count", o_out_word.used_count, e.used_count);
                if (o_out_word.lowest_used !== e.lowest_used)
                    report_mismatch("lowest_used", o_out_word.lowest_used, e.lowest_used);
                if (o_out_word.highest_used !== e.highest_used)
                    report_mismatch("highest_used", o_out_word.highest_used, e.highest_used);
            end
        end
    end

    task automatic wait_drained();
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // The tag may be written only when the block has nothing in flight.
    task automatic write_tag(logic [15:0] t);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= t;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sh_tag = t;
    endtask

    function automatic logic [63:0] random_live_handle();
        if (live_handles.size() == 0) return {$urandom, $urandom};
        return live_handles[$urandom_range(0, live_handles.size() - 1)];
    endfunction

    // Directed: empty-table corners, every mode, full table, mismatches and clear.
    task automatic test_directed();
        logic [63:0] h;
        send_word(gsa_pkg::MODE_NEXT, '0, 10'd0);
        send_word(gsa_pkg::MODE_FREE_INDEX, '0, 10'h3FF);
        send_word(gsa_pkg::MODE_ALLOC, '0, '0);
        send_word(gsa_pkg::MODE_ALLOC, '0, '0);
        send_word(gsa_pkg::MODE_ALLOC, '0, '0);
        h = live_handles[1];
        send_word(gsa_pkg::MODE_CHECK_HANDLE, h, '0);
        send_word(gsa_pkg::MODE_CHECK_HANDLE, h ^ (64'h1 << 48), '0);
        send_word(gsa_pkg::MODE_CHECK_HANDLE, h ^ (64'h1 << 16), '0);
        send_word(gsa_pkg::MODE_CHECK_HANDLE, h | 64'hFFFF_0000_0000, '0);
        send_word(gsa_pkg::MODE_CHECK_HANDLE, {h[63:16], 16'hFFFF}, '0);
        send_word(gsa_pkg::MODE_NEXT, '0, 10'd0);
        send_word(gsa_pkg::MODE_PREV, '0, 10'd2);
        send_word(gsa_pkg::MODE_CHECK_INDEX, '0, 10'd1);
        send_word(gsa_pkg::MODE_FREE_HANDLE, live_handles[0], '0);
        send_word(gsa_pkg::MODE_FREE_HANDLE, live_handles[0], '0);
        send_word(gsa_pkg::MODE_FREE_INDEX, '0, 10'd2);
        send_word(gsa_pkg::MODE_PREV, '0, 10'd1);
        send_word(gsa_pkg::MODE_CLEAR, '0, '0);
        // Fill the table to the last slot, then overflow it.
        for (int i = 0; i < NSLOT + 1; i++) send_word(gsa_pkg::MODE_ALLOC, '0, '0);
        send_word(gsa_pkg::MODE_NEXT, '0, 10'd1022);
        send_word(gsa_pkg::MODE_PREV, '0, 10'd1023);
        send_word(gsa_pkg::MODE_FREE_INDEX, '0, 10'd1023);
        send_word(gsa_pkg::MODE_FREE_INDEX, '0, 10'd0);
        send_word(gsa_pkg::MODE_ALLOC, '0, '0);
        send_word(gsa_pkg::MODE_CLEAR, '0, '0);
    endtask

    // Random: mostly handles and indices of live slots, some noise.
    task automatic test_random(int n);
        gsa_pkg::t_mode m;
        logic [63:0] h;
        logic [9:0]  si;
        int          r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            h = random_live_handle();
            si = (live_handles.size() != 0 && $urandom_range(0, 3) != 0)
                 ? h[9:0] : 10'($urandom);
            if (r < 35)      m = gsa_pkg::MODE_ALLOC;
            else if (r < 45) m = gsa_pkg::MODE_FREE_HANDLE;
            else if (r < 53) m = gsa_pkg::MODE_FREE_INDEX;
            else if (r < 63) m = gsa_pkg::MODE_CHECK_HANDLE;
            else if (r < 71) m = gsa_pkg::MODE_CHECK_INDEX;
            else if (r < 83) m = gsa_pkg::MODE_NEXT;
            else if (r < 95) m = gsa_pkg::MODE_PREV;
            else if (r < 96) m = gsa_pkg::MODE_CLEAR;
            else begin
                m = gsa_pkg::t_mode'($urandom_range(0, 6));
                h = {$urandom, $urandom};
            end
            if ($urandom_range(0, 9) == 0) h[47:32] = 16'($urandom);
            send_word(m, h, si);
        end
    endtask

    initial begin
        shadow_relink();
        sh_tag = 16'd1;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        write_tag(16'h0000);
        test_random(40);
        write_tag(16'hFFFF);
        test_random(40);
        write_tag(16'($urandom));
        test_random(80);
        wait_drained();
        repeat (2 * NSLOT + 20) @(posedge i_clk);
        $display("Sent %0d words across four tag settings; %0d results checked.",
                 word_count, result_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #50ms;
        $display("Timeout with %0d results outstanding.", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_table.sv
hw/rtl/generational_slot_allocator_top.sv
tb/testbench.sv
